// ----- src/mbed_pkg.sv -----
//------------------------------------------------------------------------------
// mbed_pkg
// Shared types and constants of the magnetometer baseline event detector.
//------------------------------------------------------------------------------
package mbed_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned ACC_W      = 16;
	localparam int unsigned POT_W      = 8;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned S_DATA_W   = 16;
	localparam int unsigned M_DATA_W   = 104;

	localparam logic [ACC_W-1:0] REBASE_OFFSET      = 16'd235;
	localparam logic [ACC_W-1:0] SETTLE_FORCE_LEVEL = 16'd100;
	localparam logic [ACC_W-1:0] SETTLE_RESET       = 16'd320;
	localparam logic [POT_W-1:0] POT_MID            = 8'd128;
	localparam logic [POT_W-1:0] POT_MAX            = 8'd255;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_X    = 2'd1,
		FUNC_Y    = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REQ_NONE = 2'd0,
		REQ_X    = 2'd1,
		REQ_Y    = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE_TICKS    = 3'd0,
		REG_OFF_RANGE_LIMIT = 3'd1,
		REG_OUTER_LOW       = 3'd2,
		REG_OUTER_HIGH      = 3'd3,
		REG_INNER_LOW       = 3'd4,
		REG_INNER_HIGH      = 3'd5,
		REG_POT_SPLIT       = 3'd6,
		REG_REPORT_HOLDOFF  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ACC_W-1:0]    off_range_limit;
		logic [SAMPLE_W-1:0] outer_low;
		logic [SAMPLE_W-1:0] outer_high;
		logic [SAMPLE_W-1:0] inner_low;
		logic [SAMPLE_W-1:0] inner_high;
		logic [SAMPLE_W-1:0] pot_split;
	} axis_cfg_t;

	typedef struct packed {
		logic upd;
		logic settling;
		logic force_count;
	} axis_ctl_t;

	typedef struct packed {
		logic [ACC_W-1:0] base;
		logic [ACC_W-1:0] fast;
		logic [POT_W-1:0] pot;
		logic             step;
	} axis_stat_t;

endpackage

// ----- src/magnetometer_baseline_event_detect.sv -----
//------------------------------------------------------------------------------
// magnetometer_baseline_event_detect
// Two-axis magnetometer front end with baseline tracking and event magnitude.
//------------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser carries the item kind (tick, X
// sample, Y sample), tdata the 10-bit converter reading. Every item yields
// exactly one result item on the m_ stream: the next sample to request, any
// offset pot write, any magnitude report and the averages and pot settings
// after the item.
// An item is registered on entry, processed by one pass of combinational
// logic (per-axis averaging and counter update, then the squared deviation)
// and loaded into the result register once that register is empty or being
// taken: the result then stands on the m_ stream until m_tready takes it.
// One item is accepted every cycle while the m_ stream is not stalled; the
// per-axis state register update is the loop that sets this rate.
// While the result register is full and m_tready is low, the entry register
// still takes one more item, then s_tready drops until the result is taken.
// Reset clears both registers, loads the settling count with 320, pots with
// 128, averages and counters with zero and all registers with their defaults.
// The user must write registers through cfg_wen/cfg_index/cfg_data only while idle; the block does not enforce it.
//------------------------------------------------------------------------------
module magnetometer_baseline_event_detect
	import mbed_pkg::*;
#(
	parameter int unsigned AVG_RATE_RELOAD = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // sample[9:0], zero fill
	input  logic [1:0]           s_tuser,   // func[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// request_axis[1:0], pot_write[2], pot_axis[3], pot_value[11:4],
	// report_valid[12], magnitude[28:13], x_fast_out[41:29], y_fast_out[54:42],
	// x_base_out[68:55], y_base_out[82:69], pot_x_out[90:83], pot_y_out[98:91]
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [7:0] RATE_RELOAD = 8'(AVG_RATE_RELOAD);

	logic                in_valid_s1;
	func_t               func_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic                advance;

	axis_cfg_t   axis_cfg_q;
	logic [7:0]  report_holdoff_q;

	logic [ACC_W-1:0] settle_q, settle_n;
	logic [7:0]       rate_q, rate_n, hold_q, hold_n;

	axis_ctl_t   ctl;
	axis_stat_t  x_stat, y_stat;
	logic        x_en, y_en;
	logic [ACC_W-1:0] mag;

	req_t             req;
	logic             pot_write, pot_axis, report;
	logic [POT_W-1:0] pot_value;
	logic [ACC_W-1:0] mag_out;

	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= func_t'(s_tuser);
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_cfg_q.off_range_limit <= 16'd32;
			axis_cfg_q.outer_low       <= 10'd300;
			axis_cfg_q.outer_high      <= 10'd700;
			axis_cfg_q.inner_low       <= 10'd400;
			axis_cfg_q.inner_high      <= 10'd600;
			axis_cfg_q.pot_split       <= 10'd500;
			report_holdoff_q           <= 8'd4;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OFF_RANGE_LIMIT: axis_cfg_q.off_range_limit <= cfg_data;
				REG_OUTER_LOW:       axis_cfg_q.outer_low  <= cfg_data[SAMPLE_W-1:0];
				REG_OUTER_HIGH:      axis_cfg_q.outer_high <= cfg_data[SAMPLE_W-1:0];
				REG_INNER_LOW:       axis_cfg_q.inner_low  <= cfg_data[SAMPLE_W-1:0];
				REG_INNER_HIGH:      axis_cfg_q.inner_high <= cfg_data[SAMPLE_W-1:0];
				REG_POT_SPLIT:       axis_cfg_q.pot_split  <= cfg_data[SAMPLE_W-1:0];
				REG_REPORT_HOLDOFF:  report_holdoff_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign x_en = advance && func_s1 == FUNC_X;
	assign y_en = advance && func_s1 == FUNC_Y;

	always_comb begin
		ctl.settling    = settle_q != '0;
		ctl.upd         = ctl.settling || rate_q == '0;
		ctl.force_count = settle_q > SETTLE_FORCE_LEVEL;
	end

	mbed_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (x_en),
		.sample (sample_s1),
		.cfg    (axis_cfg_q),
		.ctl    (ctl),
		.stat   (x_stat)
	);

	mbed_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (y_en),
		.sample (sample_s1),
		.cfg    (axis_cfg_q),
		.ctl    (ctl),
		.stat   (y_stat)
	);

	mbed_mag u_mag (
		.x_base    (x_stat.base),
		.x_fast    (x_stat.fast),
		.y_base    (y_stat.base),
		.y_fast    (y_stat.fast),
		.magnitude (mag)
	);

	always_comb begin
		settle_n  = settle_q;
		rate_n    = rate_q;
		hold_n    = hold_q;
		report    = 1'b0;
		req       = REQ_NONE;
		pot_write = 1'b0;
		pot_axis  = 1'b0;
		pot_value = '0;
		unique case (func_s1)
			FUNC_TICK: begin
				if (settle_q != '0)
					settle_n = settle_q - 1'b1;
				req = REQ_X;
			end
			FUNC_X: begin
				req = REQ_Y;
				if (x_stat.step) begin
					pot_write = 1'b1;
					pot_value = x_stat.pot;
				end
			end
			FUNC_Y: begin
				if (y_stat.step) begin
					pot_write = 1'b1;
					pot_axis  = 1'b1;
					pot_value = y_stat.pot;
				end
				rate_n = ctl.upd ? RATE_RELOAD : rate_q - 1'b1;
				if (hold_q != '0) begin
					hold_n = hold_q - 1'b1;
				end else if (settle_q == '0) begin
					report = 1'b1;
					hold_n = report_holdoff_q;
				end
			end
			FUNC_NONE: ;
			default: ;
		endcase
		mag_out = report ? mag : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			rate_q   <= '0;
			hold_q   <= '0;
		end else if (advance) begin
			settle_q <= settle_n;
			rate_q   <= rate_n;
			hold_q   <= hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'b0, y_stat.pot, x_stat.pot, y_stat.base[15:2], x_stat.base[15:2],
				y_stat.fast[15:3], x_stat.fast[15:3], mag_out, report,
				pot_value, pot_axis, pot_write, req};
		end
	end

	a_settle_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q <= $past(settle_q))
		else $error("settling count increased");

	a_report_on_y_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && report |-> func_s1 == FUNC_Y && settle_q == '0 && hold_q == '0)
		else $error("report outside a Y item");

	a_report_loads_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		advance && report |=> hold_q == $past(report_holdoff_q))
		else $error("holdoff not loaded after report");

	a_no_pot_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (func_s1 == FUNC_TICK || func_s1 == FUNC_NONE) |-> !pot_write && !report)
		else $error("pot write or report on a non-sample item");

endmodule

// ----- src/mbed_axis.sv -----
//------------------------------------------------------------------------------
// mbed_axis
// One axis: baseline and fast averages, out-of-range counter, offset pot.
//------------------------------------------------------------------------------
module mbed_axis
	import mbed_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [SAMPLE_W-1:0] sample,
	input  axis_cfg_t           cfg,
	input  axis_ctl_t           ctl,
	output axis_stat_t          stat
);

	logic [ACC_W-1:0] base_q, fast_q, cnt_q;
	logic [POT_W-1:0] pot_q;
	logic             pend_q;

	logic [ACC_W-1:0] s16, base_avg, base_n, fast_n, cnt_n;
	logic [POT_W-1:0] pot_n;
	logic             step;

	always_comb begin
		s16      = {{(ACC_W-SAMPLE_W){1'b0}}, sample};
		base_avg = ctl.upd ? (base_q - (base_q >> 5) + (s16 >> 3)) : base_q;
		base_n   = pend_q ? ((s16 - REBASE_OFFSET) << 2) : base_avg;
		fast_n   = fast_q - (fast_q >> 2) + (s16 << 1);
		cnt_n    = cnt_q;
		if (sample > cfg.outer_high || sample < cfg.outer_low || ctl.force_count) begin
			if (cnt_q != {ACC_W{1'b1}})
				cnt_n = cnt_q + 1'b1;
		end else if (sample < cfg.inner_high && sample > cfg.inner_low) begin
			cnt_n = '0;
		end
		step  = (cnt_n > cfg.off_range_limit) || (ctl.settling && cnt_n > 16'd1);
		pot_n = pot_q;
		if (step) begin
			if (sample > cfg.pot_split) begin
				if (pot_q != POT_MAX)
					pot_n = pot_q + 1'b1;
			end else begin
				if (pot_q != '0)
					pot_n = pot_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			fast_q <= '0;
			cnt_q  <= '0;
			pot_q  <= POT_MID;
			pend_q <= 1'b0;
		end else if (en) begin
			base_q <= base_n;
			fast_q <= fast_n;
			cnt_q  <= cnt_n;
			pot_q  <= pot_n;
			pend_q <= step;
		end
	end

	always_comb begin
		if (en) begin
			stat = '{base: base_n, fast: fast_n, pot: pot_n, step: step};
		end else begin
			stat = '{base: base_q, fast: fast_q, pot: pot_q, step: 1'b0};
		end
	end

endmodule

// ----- src/mbed_mag.sv -----
//------------------------------------------------------------------------------
// mbed_mag
// Squared deviation magnitude between baselines and fast averages.
//------------------------------------------------------------------------------
module mbed_mag
	import mbed_pkg::*;
(
	input  logic [ACC_W-1:0] x_base,
	input  logic [ACC_W-1:0] x_fast,
	input  logic [ACC_W-1:0] y_base,
	input  logic [ACC_W-1:0] y_fast,
	output logic [ACC_W-1:0] magnitude
);

	logic signed [14:0] dx_raw, dy_raw;
	logic signed [12:0] dx, dy;
	logic signed [25:0] sqx, sqy;

	always_comb begin
		dx_raw    = $signed({1'b0, x_base[15:2]}) - $signed({2'b00, x_fast[15:3]});
		dy_raw    = $signed({1'b0, y_base[15:2]}) - $signed({2'b00, y_fast[15:3]});
		dx        = dx_raw[14:2];
		dy        = dy_raw[14:2];
		sqx       = dx * dx;
		sqy       = dy * dy;
		magnitude = sqx[ACC_W-1:0] + sqy[ACC_W-1:0];
	end

endmodule
